// ===== rtl/rsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rsd_pkg;

    // default grid width of the linear pixel address space
    localparam int unsigned LINE_STRIDE_DEF = 640;

    // field widths
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned X_W      = 10;
    localparam int unsigned Y_W      = 16;
    localparam int unsigned CURY_W   = 24;
    localparam int unsigned POS_W    = 32;
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned IDX_W    = 4;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned OUT_DATA_W = 40;

    // special values
    localparam logic [POS_W-1:0]  TERM_POS   = 32'hFFFF_FFFF;
    localparam logic [CURY_W-1:0] CURY_MAX   = 24'hFF_FFFF;
    localparam logic [WORD_W-1:0] MODE_RLE   = 16'h0001;

    // header byte positions
    localparam logic [IDX_W-1:0] HDR_MODE_LO   = 4'd0;
    localparam logic [IDX_W-1:0] HDR_MODE_HI   = 4'd1;
    localparam logic [IDX_W-1:0] HDR_WIDTH_LO  = 4'd6;
    localparam logic [IDX_W-1:0] HDR_WIDTH_HI  = 4'd7;
    localparam logic [IDX_W-1:0] HDR_HEIGHT_LO = 4'd10;
    localparam logic [IDX_W-1:0] HDR_HEIGHT_HI = 4'd11;
    localparam logic [IDX_W-1:0] HDR_LAST      = 4'd11;

    // run record byte positions
    localparam logic [IDX_W-1:0] REC_POS_LAST = 4'd3;
    localparam logic [IDX_W-1:0] REC_BYTE4    = 4'd4;
    localparam logic [IDX_W-1:0] REC_BYTE5    = 4'd5;
    localparam logic [IDX_W-1:0] REC_BYTE6    = 4'd6;
    localparam logic [IDX_W-1:0] REC_BYTE7    = 4'd7;
    localparam logic [IDX_W-1:0] REC_LAST_A   = 4'd7;
    localparam logic [IDX_W-1:0] REC_LAST_B   = 4'd11;

    typedef enum logic [1:0] {
        PH_HALT,
        PH_HEADER,
        PH_RECORD,
        PH_PIXELS
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_PIXEL        = 2'd0,
        KIND_TERM         = 2'd1,
        KIND_BAD_MODE     = 2'd2,
        KIND_COL_MISMATCH = 2'd3
    } kind_t;

endpackage

`default_nettype wire

// ===== rtl/rle_sprite_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Run-length sprite decoder, one file byte per item.
// Input channel s_*: one file byte in s_tdata, s_tuser high on the first byte of
// a new file (restarts the parse). Output channel m_*: one result per producing
// byte: kind in m_tuser, pixel column/row/palette index in m_tdata.
// Config: cfg_wr_en/cfg_wr_data select record layout (0 = 8-byte, 1 = 12-byte);
// write only while the block holds no item.
// Throughput: one byte per cycle while the receiver is not stalling. Each byte
// needs one table lookup and a short add chain in the single processing stage;
// the start position is split into row and column byte by byte through per-byte
// quotient/remainder tables. An accepted byte waits in the input register
// until the output register is empty or drained; then any result it yields loads it.
// When the receiver stalls, the input register still takes one more byte, then
// s_tready drops until the output register is drained.
// After reset the parser is halted and ignores bytes until s_tuser marks a file
// start; format selection resets to the 8-byte layout.

module rle_sprite_decoder #(
    parameter int unsigned LINE_STRIDE = rsd_pkg::LINE_STRIDE_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // config
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_tuser,   // [0] start_of_file
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [9:0] pixel_x, [25:10] pixel_y,
                                        // [33:26] color_index, [39:34] zero
    output logic [1:0]       m_tuser    // [1:0] result_kind
);

    localparam int unsigned XW  = rsd_pkg::X_W;
    localparam logic [XW:0] StrideW = (XW+1)'(LINE_STRIDE);

    // quotient and remainder of (b << 8k) by the stride, per byte position
    logic [rsd_pkg::POS_W-1:0] quo_tab [4][256];
    logic [XW-1:0]             rem_tab [4][256];

    for (genvar gk = 0; gk < 4; gk++) begin : g_pos_byte
        for (genvar gb = 0; gb < 256; gb++) begin : g_val
            localparam logic [39:0] Val = 40'(gb) << (8 * gk);
            localparam logic [39:0] Quo = Val / LINE_STRIDE;
            localparam logic [39:0] Rem = Val % LINE_STRIDE;
            assign quo_tab[gk][gb] = Quo[rsd_pkg::POS_W-1:0];
            assign rem_tab[gk][gb] = Rem[XW-1:0];
        end
    end

    // registers
    logic                           variant_reg;
    logic                           in_valid_reg, in_valid_next;
    logic [7:0]                     in_byte_reg;
    logic                           in_sof_reg;
    logic                           out_valid_reg, out_valid_next;
    logic [rsd_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [1:0]                     out_kind_reg;

    rsd_pkg::phase_t                phase_reg, phase_next;
    logic [rsd_pkg::IDX_W-1:0]      byte_idx_reg, byte_idx_next;
    logic [rsd_pkg::WORD_W-1:0]     mode_reg, mode_next;
    logic [rsd_pkg::WORD_W-1:0]     width_reg, width_next;
    logic [rsd_pkg::WORD_W-1:0]     height_reg, height_next;
    logic [rsd_pkg::POS_W-1:0]      start_reg, start_next;
    logic [XW-1:0]                  col_reg, col_next;
    logic [rsd_pkg::POS_W-1:0]      row_reg, row_next;
    logic [rsd_pkg::WORD_W-1:0]     colchk_reg, colchk_next;
    logic [rsd_pkg::WORD_W-1:0]     left_reg, left_next;
    logic [XW-1:0]                  cur_x_reg, cur_x_next;
    logic [rsd_pkg::CURY_W-1:0]     cur_y_reg, cur_y_next;

    // processing signals
    logic                           advance;
    rsd_pkg::phase_t                eff_phase;
    logic [rsd_pkg::IDX_W-1:0]      k;
    logic [7:0]                     b;
    logic [XW:0]                    rem_sum;
    logic                           rem_wrap;
    logic [XW-1:0]                  acc_col;
    logic [rsd_pkg::POS_W-1:0]      acc_row;
    logic [rsd_pkg::IDX_W-1:0]      rec_last;
    logic [XW:0]                    x_inc;
    logic                           res_emit;
    rsd_pkg::kind_t                 res_kind;
    logic [XW-1:0]                  res_x;
    logic [rsd_pkg::Y_W-1:0]        res_y;
    logic [7:0]                     res_c;

    // handshake
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg && !m_tready;
        if (advance) begin
            out_valid_next = res_emit;
        end
    end

    // start position split: add this byte's quotient and remainder
    assign b        = in_byte_reg;
    assign rem_sum  = {1'b0, col_reg} + {1'b0, rem_tab[byte_idx_reg[1:0]][b]};
    assign rem_wrap = rem_sum >= StrideW;
    assign acc_col  = rem_wrap ? XW'(rem_sum - StrideW) : rem_sum[XW-1:0];
    assign acc_row  = row_reg + quo_tab[byte_idx_reg[1:0]][b] + rsd_pkg::POS_W'(rem_wrap);
    assign rec_last = variant_reg ? rsd_pkg::REC_LAST_B : rsd_pkg::REC_LAST_A;
    assign x_inc    = {1'b0, cur_x_reg} + (XW+1)'(1);

    // parse step for the byte in the input register
    always_comb begin
        eff_phase     = phase_reg;
        k             = byte_idx_reg;
        phase_next    = phase_reg;
        byte_idx_next = byte_idx_reg;
        mode_next     = mode_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        start_next    = start_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        colchk_next   = colchk_reg;
        left_next     = left_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        res_emit      = 1'b0;
        res_kind      = rsd_pkg::KIND_PIXEL;
        res_x         = '0;
        res_y         = '0;
        res_c         = '0;

        // file start clears the parse and makes this header byte zero
        if (in_sof_reg) begin
            eff_phase     = rsd_pkg::PH_HEADER;
            k             = '0;
            phase_next    = rsd_pkg::PH_HEADER;
            byte_idx_next = '0;
            mode_next     = '0;
            width_next    = '0;
            height_next   = '0;
            start_next    = '0;
            col_next      = '0;
            row_next      = '0;
            colchk_next   = '0;
            left_next     = '0;
            cur_x_next    = '0;
            cur_y_next    = '0;
        end

        case (eff_phase)
            rsd_pkg::PH_HEADER: begin
                case (k)
                    rsd_pkg::HDR_MODE_LO:   mode_next[7:0]    = b;
                    rsd_pkg::HDR_MODE_HI:   mode_next[15:8]   = b;
                    rsd_pkg::HDR_WIDTH_LO:  width_next[7:0]   = b;
                    rsd_pkg::HDR_WIDTH_HI:  width_next[15:8]  = b;
                    rsd_pkg::HDR_HEIGHT_LO: height_next[7:0]  = b;
                    rsd_pkg::HDR_HEIGHT_HI: height_next[15:8] = b;
                    default: ;
                endcase
                if (k >= rsd_pkg::HDR_LAST) begin
                    byte_idx_next = '0;
                    if (mode_next != rsd_pkg::MODE_RLE) begin
                        phase_next = rsd_pkg::PH_HALT;
                        res_emit   = 1'b1;
                        res_kind   = rsd_pkg::KIND_BAD_MODE;
                    end else begin
                        phase_next = rsd_pkg::PH_RECORD;
                    end
                end else begin
                    byte_idx_next = k + 1'b1;
                end
            end

            rsd_pkg::PH_RECORD: begin
                if (k == '0) begin
                    start_next  = {24'd0, b};
                    col_next    = rem_tab[0][b];
                    row_next    = quo_tab[0][b];
                    colchk_next = '0;
                    left_next   = '0;
                end else if (k <= rsd_pkg::REC_POS_LAST) begin
                    start_next = start_reg | (rsd_pkg::POS_W'(b) << {k[1:0], 3'b000});
                    col_next   = acc_col;
                    row_next   = acc_row;
                end else if (!variant_reg) begin
                    case (k)
                        rsd_pkg::REC_BYTE4: colchk_next     = {8'd0, b};
                        rsd_pkg::REC_BYTE5: left_next[7:0]  = b;
                        rsd_pkg::REC_BYTE6: left_next[15:8] = b;
                        default: ;
                    endcase
                end else begin
                    case (k)
                        rsd_pkg::REC_BYTE4: colchk_next[7:0]  = b;
                        rsd_pkg::REC_BYTE5: colchk_next[15:8] = b;
                        rsd_pkg::REC_BYTE6: left_next[7:0]    = b;
                        rsd_pkg::REC_BYTE7: left_next[15:8]   = b;
                        default: ;
                    endcase
                end
                if (k < rec_last) begin
                    byte_idx_next = k + 1'b1;
                end else begin
                    byte_idx_next = '0;
                    if (start_next == rsd_pkg::TERM_POS) begin
                        phase_next = rsd_pkg::PH_HALT;
                        res_emit   = 1'b1;
                        res_kind   = rsd_pkg::KIND_TERM;
                    end else if ({6'd0, col_next} != colchk_next) begin
                        phase_next = rsd_pkg::PH_HALT;
                        res_emit   = 1'b1;
                        res_kind   = rsd_pkg::KIND_COL_MISMATCH;
                    end else begin
                        cur_x_next = col_next;
                        cur_y_next = (|row_next[31:24]) ? rsd_pkg::CURY_MAX
                                                        : row_next[23:0];
                        phase_next = (left_next != '0) ? rsd_pkg::PH_PIXELS
                                                       : rsd_pkg::PH_RECORD;
                    end
                end
            end

            rsd_pkg::PH_PIXELS: begin
                // clipped write at the cursor
                if (({6'd0, cur_x_reg} < width_reg) &&
                    (cur_y_reg < {8'd0, height_reg})) begin
                    res_emit = 1'b1;
                    res_kind = rsd_pkg::KIND_PIXEL;
                    res_x    = cur_x_reg;
                    res_y    = cur_y_reg[15:0];
                    res_c    = b;
                end
                // cursor step with row wrap, row saturates
                if (x_inc >= StrideW) begin
                    cur_x_next = '0;
                    if (cur_y_reg != rsd_pkg::CURY_MAX) begin
                        cur_y_next = cur_y_reg + 1'b1;
                    end
                end else begin
                    cur_x_next = x_inc[XW-1:0];
                end
                left_next = left_reg - 1'b1;
                if (left_next == '0) begin
                    phase_next = rsd_pkg::PH_RECORD;
                end
            end

            default: ;
        endcase
    end

    // control and parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            variant_reg   <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= rsd_pkg::PH_HALT;
            byte_idx_reg  <= '0;
            mode_reg      <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            start_reg     <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            colchk_reg    <= '0;
            left_reg      <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                variant_reg <= cfg_wr_data;
            end
            if (advance) begin
                phase_reg    <= phase_next;
                byte_idx_reg <= byte_idx_next;
                mode_reg     <= mode_next;
                width_reg    <= width_next;
                height_reg   <= height_next;
                start_reg    <= start_next;
                col_reg      <= col_next;
                row_reg      <= row_next;
                colchk_reg   <= colchk_next;
                left_reg     <= left_next;
                cur_x_reg    <= cur_x_next;
                cur_y_reg    <= cur_y_next;
            end
        end
    end

    // input and result payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_sof_reg  <= s_tuser[0];
        end
        if (advance && res_emit) begin
            out_data_reg <= {6'd0, res_c, res_y, res_x};
            out_kind_reg <= res_kind;
        end
    end

    // non-pixel results carry zero payload
    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_kind_reg != rsd_pkg::KIND_PIXEL)) |-> (out_data_reg == '0))
        else $error("status result with nonzero payload");

    // every status result halts the parser
    a_status_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res_emit && (res_kind != rsd_pkg::KIND_PIXEL))
        |=> (phase_reg == rsd_pkg::PH_HALT))
        else $error("parser not halted after status result");

    // cursor column stays inside the grid
    a_cursor_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, cur_x_reg} < StrideW))
        else $error("cursor column beyond stride");

    // pixel phase always has pixels left
    a_pixels_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == rsd_pkg::PH_PIXELS) |-> (left_reg != '0))
        else $error("pixel phase with zero count");

endmodule

`default_nettype wire

// ===== verif/rsd_decode_checker.sv =====
`timescale 1ns / 1ps

module rsd_decode_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] data_byte
    input  logic [0:0]        s_tuser,   // [0] start_of_file
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [39:0]       m_tdata,   // [9:0] x, [25:10] y, [33:26] color, [39:34] zero
    input  logic [1:0]        m_tuser,   // [1:0] result_kind
    output int unsigned       mismatch_cnt,
    output int unsigned       pending_cnt,
    output int unsigned       checked_cnt
);

    typedef struct packed {
        rsd_pkg::kind_t kind;
        logic [9:0]     x;
        logic [15:0]    y;
        logic [7:0]     color;
    } decode_out_t;

    // results predicted from accepted bytes, oldest first
    decode_out_t predicted_q[$];

    // shadow of the decoder state
    logic                       layout_b;
    rsd_pkg::phase_t            phase;
    logic [rsd_pkg::IDX_W-1:0]  byte_idx;
    logic [rsd_pkg::WORD_W-1:0] mode_w;
    logic [rsd_pkg::WORD_W-1:0] img_w;
    logic [rsd_pkg::WORD_W-1:0] img_h;
    logic [rsd_pkg::WORD_W-1:0] col_chk;
    logic [rsd_pkg::WORD_W-1:0] run_left;
    logic [rsd_pkg::POS_W-1:0]  run_start;
    logic [rsd_pkg::X_W-1:0]    cur_x;
    logic [rsd_pkg::CURY_W-1:0] cur_y;

    function automatic decode_out_t result_of(rsd_pkg::kind_t k, logic [9:0] x,
                                              logic [15:0] y, logic [7:0] c);
        decode_out_t r;
        r.kind  = k;
        r.x     = x;
        r.y     = y;
        r.color = c;
        return r;
    endfunction

    task automatic clear_parse();
        byte_idx  = '0;
        mode_w    = '0;
        img_w     = '0;
        img_h     = '0;
        run_start = '0;
        col_chk   = '0;
        run_left  = '0;
        cur_x     = '0;
        cur_y     = '0;
    endtask

    task automatic note_mismatch(input string what, input logic [39:0] want,
                                 input logic [39:0] got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("mismatch %0d at %0t ns, result %0d: %s expected %0h got %0h",
                     mismatch_cnt, $time, checked_cnt, what, want, got);
    endtask

    // advance the shadow parser by one file byte
    task automatic decode_file_byte(input logic [7:0] b, input logic sof);
        logic [rsd_pkg::IDX_W-1:0] last;
        logic [rsd_pkg::POS_W-1:0] col;
        logic [rsd_pkg::POS_W-1:0] row;
        if (sof) begin
            clear_parse();
            phase = rsd_pkg::PH_HEADER;
        end
        case (phase)
            rsd_pkg::PH_HEADER: begin
                case (byte_idx)
                    rsd_pkg::HDR_MODE_LO:   mode_w[7:0]  = b;
                    rsd_pkg::HDR_MODE_HI:   mode_w[15:8] = b;
                    rsd_pkg::HDR_WIDTH_LO:  img_w[7:0]   = b;
                    rsd_pkg::HDR_WIDTH_HI:  img_w[15:8]  = b;
                    rsd_pkg::HDR_HEIGHT_LO: img_h[7:0]   = b;
                    rsd_pkg::HDR_HEIGHT_HI: img_h[15:8]  = b;
                    default: ;
                endcase
                if (byte_idx >= rsd_pkg::HDR_LAST) begin
                    byte_idx = '0;
                    if (mode_w != rsd_pkg::MODE_RLE) begin
                        phase = rsd_pkg::PH_HALT;
                        predicted_q.push_back(result_of(rsd_pkg::KIND_BAD_MODE,
                                                        '0, '0, '0));
                    end else begin
                        phase = rsd_pkg::PH_RECORD;
                    end
                end else begin
                    byte_idx = byte_idx + 1'b1;
                end
            end
            rsd_pkg::PH_RECORD: begin
                last = layout_b ? rsd_pkg::REC_LAST_B : rsd_pkg::REC_LAST_A;
                if (byte_idx == '0) begin
                    run_start = {24'd0, b};
                    col_chk   = '0;
                    run_left  = '0;
                end else if (byte_idx <= rsd_pkg::REC_POS_LAST) begin
                    run_start = run_start | ({24'd0, b} << (8 * byte_idx));
                end else if (!layout_b) begin
                    // 8-byte layout: column is one byte
                    if (byte_idx == rsd_pkg::REC_BYTE4)      col_chk        = {8'd0, b};
                    else if (byte_idx == rsd_pkg::REC_BYTE5) run_left[7:0]  = b;
                    else if (byte_idx == rsd_pkg::REC_BYTE6) run_left[15:8] = b;
                end else begin
                    if (byte_idx == rsd_pkg::REC_BYTE4)      col_chk[7:0]   = b;
                    else if (byte_idx == rsd_pkg::REC_BYTE5) col_chk[15:8]  = b;
                    else if (byte_idx == rsd_pkg::REC_BYTE6) run_left[7:0]  = b;
                    else if (byte_idx == rsd_pkg::REC_BYTE7) run_left[15:8] = b;
                end
                if (byte_idx < last) begin
                    byte_idx = byte_idx + 1'b1;
                end else begin
                    // record complete
                    byte_idx = '0;
                    col = run_start % rsd_pkg::LINE_STRIDE_DEF;
                    row = run_start / rsd_pkg::LINE_STRIDE_DEF;
                    if (run_start == rsd_pkg::TERM_POS) begin
                        phase = rsd_pkg::PH_HALT;
                        predicted_q.push_back(result_of(rsd_pkg::KIND_TERM,
                                                        '0, '0, '0));
                    end else if (col != {16'd0, col_chk}) begin
                        phase = rsd_pkg::PH_HALT;
                        predicted_q.push_back(result_of(rsd_pkg::KIND_COL_MISMATCH,
                                                        '0, '0, '0));
                    end else begin
                        cur_x = col[rsd_pkg::X_W-1:0];
                        cur_y = (row > rsd_pkg::CURY_MAX) ? rsd_pkg::CURY_MAX
                                                          : row[rsd_pkg::CURY_W-1:0];
                        phase = (run_left != '0) ? rsd_pkg::PH_PIXELS : rsd_pkg::PH_RECORD;
                    end
                end
            end
            rsd_pkg::PH_PIXELS: begin
                if (cur_x < img_w && cur_y < img_h)
                    predicted_q.push_back(result_of(rsd_pkg::KIND_PIXEL, cur_x,
                                                    cur_y[15:0], b));
                // step along the linear grid, wrapping to the next row
                if (cur_x + 1 >= rsd_pkg::LINE_STRIDE_DEF) begin
                    cur_x = '0;
                    if (cur_y < rsd_pkg::CURY_MAX) cur_y = cur_y + 1'b1;
                end else begin
                    cur_x = cur_x + 1'b1;
                end
                run_left = run_left - 1'b1;
                if (run_left == '0) phase = rsd_pkg::PH_RECORD;
            end
            default: ;
        endcase
    endtask

    // watch both channels and the register write port
    always @(posedge aclk) begin
        decode_out_t want;
        if (!aresetn) begin
            layout_b     = 1'b0;
            phase        = rsd_pkg::PH_HALT;
            clear_parse();
            predicted_q.delete();
            mismatch_cnt = 0;
            checked_cnt  = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (predicted_q.size() == 0) begin
                    note_mismatch("result with nothing predicted, tuser/tdata",
                                  '0, {m_tuser, m_tdata[37:0]});
                end else begin
                    want = predicted_q.pop_front();
                    if (m_tuser != want.kind)
                        note_mismatch("result_kind", 40'(want.kind), 40'(m_tuser));
                    if (m_tdata[9:0] != want.x)
                        note_mismatch("pixel_x", 40'(want.x), 40'(m_tdata[9:0]));
                    if (m_tdata[25:10] != want.y)
                        note_mismatch("pixel_y", 40'(want.y), 40'(m_tdata[25:10]));
                    if (m_tdata[33:26] != want.color)
                        note_mismatch("color_index", 40'(want.color), 40'(m_tdata[33:26]));
                    if (m_tdata[39:34] != '0)
                        note_mismatch("tdata fill bits", '0, 40'(m_tdata[39:34]));
                    checked_cnt++;
                end
            end
            if (cfg_wr_en) layout_b = cfg_wr_data;
            if (s_tvalid && s_tready) decode_file_byte(s_tdata, s_tuser[0]);
        end
        pending_cnt <= predicted_q.size();
    end

endmodule

// ===== verif/tb_rle_sprite_decoder.sv =====
`timescale 1ns / 1ps

module tb_rle_sprite_decoder;

    localparam int unsigned ITEM_TARGET  = 1050;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned DRAIN_LIMIT  = 5000;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic [7:0]  s_tdata     = 8'd0;
    logic [0:0]  s_tuser     = 1'b0;
    logic        m_tready    = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [39:0] m_tdata;
    wire  [1:0]  m_tuser;

    int unsigned mismatch_cnt;
    int unsigned pending_cnt;
    int unsigned checked_cnt;
    int unsigned items_sent = 0;

    bit   src_gaps    = 1'b1;
    bit   sink_stalls = 1'b1;
    logic layout_sel  = 1'b0;

    rle_sprite_decoder u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    rsd_decode_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .mismatch_cnt (mismatch_cnt),
        .pending_cnt  (pending_cnt),
        .checked_cnt  (checked_cnt)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side back-pressure
    always @(posedge aclk) begin
        m_tready <= !(sink_stalls && $urandom_range(0, 99) < 9);
    end

    // one file byte over the input channel, with random gaps before it
    task automatic put_byte(input logic [7:0] b, input logic sof, input bit counted);
        while (src_gaps && $urandom_range(0, 99) < 9) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= sof;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (counted) items_sent++;
    endtask

    task automatic put_word(input logic [15:0] w);
        put_byte(w[7:0], 1'b0, 1'b1);
        put_byte(w[15:8], 1'b0, 1'b1);
    endtask

    // header: mode, unused, left clip, width, top clip, height
    task automatic put_header(input logic [15:0] mode, input logic [15:0] wid,
                              input logic [15:0] hgt);
        put_byte(mode[7:0], 1'b1, 1'b1);
        put_byte(mode[15:8], 1'b0, 1'b1);
        repeat (4) put_byte(8'($urandom), 1'b0, 1'b1);
        put_word(wid);
        repeat (2) put_byte(8'($urandom), 1'b0, 1'b1);
        put_word(hgt);
    endtask

    // run record in the layout currently selected
    task automatic put_record(input logic [31:0] start, input logic [15:0] col,
                              input logic [15:0] cnt);
        for (int i = 0; i < 4; i++) put_byte(start[8*i +: 8], 1'b0, 1'b1);
        if (!layout_sel) begin
            put_byte(col[7:0], 1'b0, 1'b1);
            put_word(cnt);
            put_byte(8'($urandom), 1'b0, 1'b1);
        end else begin
            put_word(col);
            put_word(cnt);
            repeat (4) put_byte(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    // hold the sender until every predicted result is out and the pipe is empty
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_cnt != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_layout(input logic v);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        layout_sel   = v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // stimulus
    initial begin
        logic [15:0] wid;
        logic [15:0] hgt;
        logic [15:0] mode;
        logic [15:0] colv;
        logic [31:0] start;
        int unsigned pick;
        int unsigned row;
        int unsigned row_lim;
        int unsigned col;
        int unsigned cnt;
        int unsigned drain;
        bit          deep;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // bytes before any file start are dropped
        put_byte(8'h00, 1'b0, 1'b0);
        put_byte(8'hFF, 1'b0, 1'b0);
        set_layout(1'b0);

        // widest clip window, two pixels with extreme palette values
        put_header(rsd_pkg::MODE_RLE, 16'hFFFF, 16'hFFFF);
        put_record(32'd255, 16'd255, 16'd2);
        put_byte(8'h00, 1'b0, 1'b1);
        put_byte(8'hFF, 1'b0, 1'b1);

        // layout switch inside a record: a 12-byte record cut short by the 8-byte layout
        set_layout(1'b1);
        put_byte(8'h03, 1'b0, 1'b1);
        repeat (3) put_byte(8'h00, 1'b0, 1'b1);
        put_word(16'd3);
        put_word(16'd1);
        set_layout(1'b0);
        put_byte(8'h5A, 1'b0, 1'b1);
        put_byte(8'hA5, 1'b0, 1'b1);

        // random files in four layout phases, the third with no idling on either side
        for (int p = 0; p < 4; p++) begin
            set_layout(p % 2 == 0);
            src_gaps    = (p != 2);
            sink_stalls = (p != 2);
            while (items_sent < ITEM_TARGET * (p + 1) / 4) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    // well-formed file with random geometry and runs
                    pick = $urandom_range(0, 9);
                    if (pick == 0)      wid = 16'd0;
                    else if (pick == 1) wid = 16'($urandom_range(641, 65534));
                    else if (pick == 2) wid = 16'hFFFF;
                    else if (pick < 6)  wid = 16'($urandom_range(1, 64));
                    else                wid = 16'($urandom_range(1, 640));
                    pick = $urandom_range(0, 9);
                    if (pick == 0)      hgt = 16'd0;
                    else if (pick == 1) hgt = 16'hFFFF;
                    else                hgt = 16'($urandom_range(1, 40));
                    deep    = (hgt == 16'hFFFF) && ($urandom_range(0, 1) == 1);
                    row_lim = (hgt > 40) ? 40 : hgt + 2;
                    put_header(rsd_pkg::MODE_RLE, wid, hgt);
                    repeat ($urandom_range(1, 5)) begin
                        row = deep ? $urandom_range(0, 65535) : $urandom_range(0, row_lim);
                        if (!layout_sel)                    col = $urandom_range(0, 255);
                        else if ($urandom_range(0, 3) == 0) col = $urandom_range(620, 639);
                        else                                col = $urandom_range(0, 639);
                        pick = $urandom_range(0, 9);
                        if (pick == 0)      cnt = 0;
                        else if (pick == 1) cnt = $urandom_range(30, 70);
                        else                cnt = $urandom_range(1, 16);
                        start = row * rsd_pkg::LINE_STRIDE_DEF + col;
                        put_record(start, 16'(col), 16'(cnt));
                        repeat (cnt) put_byte(8'($urandom), 1'b0, 1'b1);
                    end
                    pick = $urandom_range(0, 9);
                    if (pick < 8)
                        put_record(rsd_pkg::TERM_POS, 16'($urandom), 16'($urandom));
                    else if (pick == 8)
                        repeat ($urandom_range(1, 6)) put_byte(8'($urandom), 1'b0, 1'b1);
                    // otherwise the next file start cuts this one off
                end else if (pick < 80) begin
                    // bad mode word, then bytes that the halted parser drops
                    mode = 16'($urandom);
                    if (mode == rsd_pkg::MODE_RLE) mode = 16'h0100;
                    put_header(mode, 16'($urandom), 16'($urandom));
                    repeat ($urandom_range(0, 4)) put_byte(8'($urandom), 1'b0, 1'b0);
                end else if (pick < 90) begin
                    // column check off by one flipped bit
                    put_header(rsd_pkg::MODE_RLE, 16'($urandom), 16'($urandom));
                    start = $urandom;
                    if (start == rsd_pkg::TERM_POS) start = 32'd0;
                    colv = 16'(start % rsd_pkg::LINE_STRIDE_DEF) ^
                           (16'd1 << $urandom_range(0, layout_sel ? 15 : 7));
                    put_record(start, colv, 16'($urandom));
                    repeat ($urandom_range(0, 3)) put_byte(8'($urandom), 1'b0, 1'b0);
                end else begin
                    // raw noise with occasional file starts
                    repeat ($urandom_range(3, 12))
                        put_byte(8'($urandom), $urandom_range(0, 7) == 0, 1'b1);
                end
            end
        end

        // drain
        s_tvalid <= 1'b0;
        @(posedge aclk);
        drain = 0;
        while (pending_cnt != 0 && drain < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d file bytes over both record layouts with seven layout writes",
                 items_sent);
        $display("checked %0d results: pixel writes, terminators, bad modes, column checks",
                 checked_cnt);
        if (pending_cnt != 0)
            $display("%0d predicted results never came out", pending_cnt);
        if (mismatch_cnt == 0 && pending_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("watchdog expired with %0d results outstanding", pending_cnt);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
